>>> hw/rtl/bf3_pkg.sv
// Shared types and constants for the 3x3 RGB box filter.
package bf3_pkg;

   localparam int CH_W                 = 16;
   localparam int POS_W                = 9;
   localparam int DIM_W                = 10;
   localparam int DEFAULT_MAX_DIM      = 512;
   localparam int DEFAULT_CHANNEL_BITS = 16;
   localparam int CSR_ADDR_W           = 3;
   localparam int CSR_DATA_W           = 32;

   localparam logic [DIM_W-1:0]        DIM_RESET     = 10'd512;
   localparam logic [CSR_ADDR_W-3:0]   REG_IMAGE_DIM = 1'b0;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [CH_W-1:0]  out_red;
      logic [CH_W-1:0]  out_green;
      logic [CH_W-1:0]  out_blue;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_end;
   } rsp_payload_type;

   // One output pixel to be formed from the current window.
   typedef struct packed {
      logic             row_lo;
      logic             col_lo;
      logic             frame_end;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } emit_type;

endpackage

>>> hw/rtl/bf3_ram.sv
// Generic single-clock RAM, one write and one registered read port.
module bf3_ram #(
   parameter int  WIDTH     = 32,
   parameter int  DEPTH     = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when both ports hit one address.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/bf3_mean.sv
// Window sum, divide by 4, 6 or 9, and the result output register.
module bf3_mean
   import bf3_pkg::*;
#(
   parameter int  CHANNEL_BITS = DEFAULT_CHANNEL_BITS,
   localparam int PIX_BITS     = 3 * CHANNEL_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      emit_valid,
   output logic                      emit_ready,
   input  emit_type                  emit,
   input  logic [8:0][PIX_BITS-1:0]  window,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_data
);

   localparam int SUM_BITS  = CHANNEL_BITS + 4;
   localparam int K         = CHANNEL_BITS + 8;
   localparam int MUL_BITS  = K - 1;
   localparam int PROD_BITS = SUM_BITS + MUL_BITS;

   // Reciprocals rounded up; exact for every sum below 2**SUM_BITS.
   localparam logic [MUL_BITS-1:0] M4 = MUL_BITS'((2**K) / 4);
   localparam logic [MUL_BITS-1:0] M6 = MUL_BITS'((2**K + 5) / 6);
   localparam logic [MUL_BITS-1:0] M9 = MUL_BITS'((2**K + 8) / 9);

   typedef enum logic [1:0] {
      DIV_4,
      DIV_6,
      DIV_9
   } div_type;

   logic [2:0][2:0][SUM_BITS-1:0] col_sum;
   logic [2:0][SUM_BITS-1:0]      sum_in;
   logic [2:0][SUM_BITS-1:0]      sum_ff;
   div_type                       div_in;
   div_type                       div_ff;
   logic [POS_W-1:0]              row_ff;
   logic [POS_W-1:0]              col_ff;
   logic                          frame_end_ff;
   logic                          s3_valid_ff;
   logic                          out_take;
   logic [MUL_BITS-1:0]           mult;
   logic [2:0][PROD_BITS-1:0]     prod;
   rsp_payload_type               rsp_data_in;
   rsp_payload_type               rsp_data_ff;
   logic                          rsp_valid_ff;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int x = 0; x < 3; x++) begin
            col_sum[ch][x] =
               (emit.row_lo ? '0 : SUM_BITS'(window[x*3][ch*CHANNEL_BITS +: CHANNEL_BITS]))
               + SUM_BITS'(window[x*3+1][ch*CHANNEL_BITS +: CHANNEL_BITS])
               + SUM_BITS'(window[x*3+2][ch*CHANNEL_BITS +: CHANNEL_BITS]);
         end
         sum_in[ch] = (emit.col_lo ? '0 : col_sum[ch][0]) + col_sum[ch][1] + col_sum[ch][2];
      end
   end

   always_comb begin
      if (emit.row_lo && emit.col_lo) begin
         div_in = DIV_4;
      end else if (emit.row_lo || emit.col_lo) begin
         div_in = DIV_6;
      end else begin
         div_in = DIV_9;
      end
   end

   assign out_take   = !rsp_valid_ff || rsp_ready;
   assign emit_ready = !s3_valid_ff || out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_ready) begin
            s3_valid_ff <= emit_valid;
         end
         if (out_take) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid && emit_ready) begin
         sum_ff       <= sum_in;
         div_ff       <= div_in;
         row_ff       <= emit.row;
         col_ff       <= emit.col;
         frame_end_ff <= emit.frame_end;
      end
   end

   always_comb begin
      unique case (div_ff)
         DIV_4:   mult = M4;
         DIV_6:   mult = M6;
         DIV_9:   mult = M9;
         default: mult = M9;
      endcase
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         prod[ch] = PROD_BITS'(sum_ff[ch]) * PROD_BITS'(mult);
      end
      rsp_data_in.out_red   = CH_W'(prod[0][K +: CHANNEL_BITS]);
      rsp_data_in.out_green = CH_W'(prod[1][K +: CHANNEL_BITS]);
      rsp_data_in.out_blue  = CH_W'(prod[2][K +: CHANNEL_BITS]);
      rsp_data_in.out_row   = row_ff;
      rsp_data_in.out_col   = col_ff;
      rsp_data_in.frame_end = frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && out_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/box_filter_3x3_rgb_unit.sv
// Top level of the 3x3 RGB box filter (per-channel mean, window clipped to the image).
// Usage: set image_dim (side of the square image, 2..MAX_DIM; outside that it is
// clamped) through the csr_ APB port while the block is idle; a write also restarts
// the frame at pixel (0,0). Pixels enter on req_ in raster order, one per request.
// Mean pixels leave on rsp_ tagged with row and column; frame_end marks (dim-1,dim-1).
// Output (R,C) is formed once pixel (R+1,C+1) is in; the last column and last row
// come out with the pixels that close them.
// Throughput: one pixel per cycle while rsp_ready is high and each pixel completes at
// most one output pixel. A pixel that completes more (two at a row end after the first
// row or in the last row, four at the frame's last pixel) holds the window stage, with
// req_ready low, until all leave; it emits one output pixel per cycle while not stalled.
// Path: the results of an accepted pixel pass the line store read, the window register,
// the sum register, and the divide into the output register before they show on rsp_valid.
// Reset (synchronous) empties the pipeline, sets image_dim to 512 and the position
// to (0,0); line stores need no clearing. When rsp_ready is low the pipeline holds
// and fills, then req_ready goes low.
module box_filter_3x3_rgb_unit
   import bf3_pkg::*;
#(
   parameter int MAX_DIM      = DEFAULT_MAX_DIM,
   parameter int CHANNEL_BITS = DEFAULT_CHANNEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_BITS = $clog2(MAX_DIM);
   localparam int PIX_BITS = 3 * CHANNEL_BITS;
   localparam int EXT_BITS = (COL_BITS + 1 > DIM_W) ? COL_BITS + 1 : DIM_W;

   logic [DIM_W-1:0]              dim_ff;
   logic [EXT_BITS-1:0]           dim_ext;
   logic [EXT_BITS-1:0]           dim_eff;
   logic [COL_BITS-1:0]           dim_last;
   logic                          csr_write;
   logic                          csr_dim_write;

   logic [COL_BITS-1:0]           row_ff;
   logic [COL_BITS-1:0]           col_ff;
   logic                          req_accept;
   logic [PIX_BITS-1:0]           pix_in;
   logic [3:0]                    mask_in;

   logic                          s1_valid_ff;
   logic [PIX_BITS-1:0]           s1_pix_ff;
   logic [COL_BITS-1:0]           s1_row_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic [3:0]                    s1_mask_ff;
   logic                          s1_row_ge2_ff;
   logic                          s1_col_ge2_ff;
   logic                          s1_move;
   logic                          older_wr_ff;

   logic [PIX_BITS-1:0]           prev_rd;
   logic [PIX_BITS-1:0]           older_rd;

   logic [8:0][PIX_BITS-1:0]      window_ff;
   logic [3:0]                    s2_mask_ff;
   logic [3:0]                    s2_lowest;
   logic [COL_BITS-1:0]           s2_row_ff;
   logic [COL_BITS-1:0]           s2_col_ff;
   logic [COL_BITS-1:0]           s2_row_m1;
   logic [COL_BITS-1:0]           s2_col_m1;
   logic                          s2_row_ge2_ff;
   logic                          s2_col_ge2_ff;
   logic                          s2_free;
   logic                          emit_valid;
   logic                          emit_ready;
   logic                          emit_go;
   emit_type                      emit_in;

   // Configuration port
   assign csr_pready    = 1'b1;
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_dim_write = csr_write && (csr_paddr[CSR_ADDR_W-1:2] == REG_IMAGE_DIM);
   assign csr_prdata    = (csr_paddr[CSR_ADDR_W-1:2] == REG_IMAGE_DIM)
                          ? CSR_DATA_W'(dim_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_dim_write) begin
         dim_ff <= csr_pwdata[DIM_W-1:0];
      end
   end

   always_comb begin
      dim_ext = EXT_BITS'(dim_ff);
      if (dim_ext < EXT_BITS'(2)) begin
         dim_eff = EXT_BITS'(2);
      end else if (dim_ext > EXT_BITS'(MAX_DIM)) begin
         dim_eff = EXT_BITS'(MAX_DIM);
      end else begin
         dim_eff = dim_ext;
      end
      dim_last = COL_BITS'(dim_eff - EXT_BITS'(1));
   end

   // Input position and request stage
   assign req_accept = req_valid && req_ready;
   assign req_ready  = !s1_valid_ff || s1_move;
   assign pix_in     = {req_data.blue[CHANNEL_BITS-1:0],
                        req_data.green[CHANNEL_BITS-1:0],
                        req_data.red[CHANNEL_BITS-1:0]};

   always_comb begin
      mask_in[0] = (row_ff != '0) && (col_ff != '0);
      mask_in[1] = (row_ff != '0) && (col_ff == dim_last);
      mask_in[2] = (row_ff == dim_last) && (col_ff != '0);
      mask_in[3] = (row_ff == dim_last) && (col_ff == dim_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (csr_dim_write) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_accept) begin
         if (col_ff == dim_last) begin
            col_ff <= '0;
            row_ff <= (row_ff == dim_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         older_wr_ff <= 1'b0;
      end else begin
         older_wr_ff <= req_accept;
         if (req_ready) begin
            s1_valid_ff <= req_accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= pix_in;
         s1_row_ff     <= row_ff;
         s1_col_ff     <= col_ff;
         s1_mask_ff    <= mask_in;
         s1_row_ge2_ff <= row_ff > COL_BITS'(1);
         s1_col_ge2_ff <= col_ff > COL_BITS'(1);
      end
   end

   // Line stores: prev takes the new pixel now, older takes the old prev in the cycle after
   bf3_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_DIM)
   ) u_line_prev (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data (pix_in),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (prev_rd)
   );

   bf3_ram #(
      .WIDTH (PIX_BITS),
      .DEPTH (MAX_DIM)
   ) u_line_older (
      .clock   (clock),
      .wr_en   (older_wr_ff),
      .wr_addr (s1_col_ff),
      .wr_data (prev_rd),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   // Window stage: shift in one column per pixel, then emit its results lowest first
   assign emit_valid = (s2_mask_ff != '0);
   assign emit_go    = emit_valid && emit_ready;
   assign s2_lowest  = s2_mask_ff & (~s2_mask_ff + 4'd1);
   assign s2_free    = !emit_valid || (emit_go && ((s2_mask_ff & ~s2_lowest) == '0));
   assign s1_move    = s1_valid_ff && s2_free;
   assign s2_row_m1  = s2_row_ff - 1'b1;
   assign s2_col_m1  = s2_col_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else if (s1_move) begin
         s2_mask_ff <= s1_mask_ff;
      end else if (emit_go) begin
         s2_mask_ff <= s2_mask_ff & ~s2_lowest;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         window_ff[5:0] <= window_ff[8:3];
         window_ff[6]   <= older_rd;
         window_ff[7]   <= prev_rd;
         window_ff[8]   <= s1_pix_ff;
         s2_row_ff      <= s1_row_ff;
         s2_col_ff      <= s1_col_ff;
         s2_row_ge2_ff  <= s1_row_ge2_ff;
         s2_col_ge2_ff  <= s1_col_ge2_ff;
      end
   end

   always_comb begin
      if (s2_mask_ff[0]) begin
         emit_in.row_lo    = !s2_row_ge2_ff;
         emit_in.col_lo    = !s2_col_ge2_ff;
         emit_in.frame_end = 1'b0;
         emit_in.row       = POS_W'(s2_row_m1);
         emit_in.col       = POS_W'(s2_col_m1);
      end else if (s2_mask_ff[1]) begin
         emit_in.row_lo    = !s2_row_ge2_ff;
         emit_in.col_lo    = 1'b1;
         emit_in.frame_end = 1'b0;
         emit_in.row       = POS_W'(s2_row_m1);
         emit_in.col       = POS_W'(s2_col_ff);
      end else if (s2_mask_ff[2]) begin
         emit_in.row_lo    = 1'b1;
         emit_in.col_lo    = !s2_col_ge2_ff;
         emit_in.frame_end = 1'b0;
         emit_in.row       = POS_W'(s2_row_ff);
         emit_in.col       = POS_W'(s2_col_m1);
      end else begin
         emit_in.row_lo    = 1'b1;
         emit_in.col_lo    = 1'b1;
         emit_in.frame_end = 1'b1;
         emit_in.row       = POS_W'(s2_row_ff);
         emit_in.col       = POS_W'(s2_col_ff);
      end
   end

   bf3_mean #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_mean (
      .clock      (clock),
      .reset      (reset),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .emit       (emit_in),
      .window     (window_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

`ifndef ASSERT_OFF
   a_frame_end_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |->
         (rsp_data.out_row == POS_W'(dim_last)) && (rsp_data.out_col == POS_W'(dim_last)))
      else $error("frame_end on a pixel other than the last one");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= dim_last) && (col_ff <= dim_last))
      else $error("input position outside the image");

   a_last_mask: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_mask_ff[3] |-> (s1_mask_ff == 4'hF))
      else $error("last pixel request without all four results");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      emit_valid && !emit_ready |=> (s2_mask_ff == $past(s2_mask_ff)))
      else $error("pending results changed while the mean stage stalled");
`endif

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the 3x3 RGB box filter: predicts every mean pixel and compares.
`timescale 1ns / 100ps

module testbench;
   import bf3_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_SIDE     = DEFAULT_MAX_DIM;

   localparam logic [CSR_ADDR_W-3:0] REG_SPARE      = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_IMAGE_DIM = {REG_IMAGE_DIM, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE     = {REG_SPARE, 2'b00};

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_payload_type       req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int send_idle_pct = 30;
   int rsp_idle_pct  = 85;
   int cycle_count   = 0;
   int error_count   = 0;

   // Filter state as the predictor sees it.
   logic [DIM_W-1:0] dim_cfg = DIM_RESET;
   int unsigned      row_pos = 0;
   int unsigned      col_pos = 0;
   req_payload_type  prev_line [MAX_SIDE] = '{default: '0};
   req_payload_type  older_line [MAX_SIDE] = '{default: '0};
   req_payload_type  win [9] = '{default: '0};

   rsp_payload_type  mean_q [$];
   rsp_payload_type  expected_mean;

   box_filter_3x3_rgb_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Sample between edges: what is seen here is what the next rising edge accepts.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (mean_q.size() == 0) begin
            $display("%0t: unexpected pixel r=%h g=%h b=%h row=%0d col=%0d end=%b", $time,
                     rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                     rsp_data.out_row, rsp_data.out_col, rsp_data.frame_end);
            error_count++;
         end else begin
            expected_mean = mean_q.pop_front();
            if (rsp_data !== expected_mean) begin
               $display("%0t: expected r=%h g=%h b=%h row=%0d col=%0d end=%b", $time,
                        expected_mean.out_red, expected_mean.out_green,
                        expected_mean.out_blue, expected_mean.out_row,
                        expected_mean.out_col, expected_mean.frame_end);
               $display("%0t: actual   r=%h g=%h b=%h row=%0d col=%0d end=%b", $time,
                        rsp_data.out_red, rsp_data.out_green, rsp_data.out_blue,
                        rsp_data.out_row, rsp_data.out_col, rsp_data.frame_end);
               error_count++;
            end
         end
      end
   end

   function automatic rsp_payload_type window_mean(input int unsigned row_lo, col_lo,
                                                   input int unsigned row, col,
                                                   input logic last);
      int unsigned     sum_r, sum_g, sum_b, cnt;
      int              x, y;
      rsp_payload_type m;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      cnt   = (3 - row_lo) * (3 - col_lo);
      for (x = col_lo; x < 3; x++) begin
         for (y = row_lo; y < 3; y++) begin
            sum_r += win[x*3 + y].red;
            sum_g += win[x*3 + y].green;
            sum_b += win[x*3 + y].blue;
         end
      end
      m.out_red   = CH_W'(sum_r / cnt);
      m.out_green = CH_W'(sum_g / cnt);
      m.out_blue  = CH_W'(sum_b / cnt);
      m.out_row   = row[POS_W-1:0];
      m.out_col   = col[POS_W-1:0];
      m.frame_end = last;
      return m;
   endfunction

   // Advance the window and line stores by one pixel and queue the means it completes.
   task automatic predict_means(input req_payload_type px);
      int unsigned d, r, c, row_lo, col_lo;
      int          k;
      d = (dim_cfg < 2) ? 2 : (dim_cfg > MAX_SIDE) ? MAX_SIDE : dim_cfg;
      r = row_pos;
      c = col_pos;
      if (r >= d || c >= d) begin
         r = 0;
         c = 0;
      end
      for (k = 0; k < 6; k++) win[k] = win[k+3];
      win[6]        = older_line[c];
      win[7]        = prev_line[c];
      win[8]        = px;
      older_line[c] = prev_line[c];
      prev_line[c]  = px;
      row_lo = (r >= 2) ? 0 : 1;
      col_lo = (c >= 2) ? 0 : 1;
      if (r >= 1 && c >= 1)     mean_q.push_back(window_mean(row_lo, col_lo, r-1, c-1, 1'b0));
      if (r >= 1 && c == d-1)   mean_q.push_back(window_mean(row_lo, 1, r-1, c, 1'b0));
      if (r == d-1 && c >= 1)   mean_q.push_back(window_mean(1, col_lo, r, c-1, 1'b0));
      if (r == d-1 && c == d-1) mean_q.push_back(window_mean(1, 1, r, c, 1'b1));
      c++;
      if (c >= d) begin
         c = 0;
         r++;
         if (r >= d) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      px.red   = CH_W'($urandom);
      px.green = CH_W'($urandom);
      px.blue  = CH_W'($urandom);
      // Push every channel of some pixels to the rails so the sums hit their extremes.
      if ($urandom_range(7) == 0) begin
         px.red   = $urandom_range(1) ? '1 : '0;
         px.green = $urandom_range(1) ? '1 : '0;
         px.blue  = $urandom_range(1) ? '1 : '0;
      end
      return px;
   endfunction

   // Send a run of pixels; valid drops only in a gap or after the last request.
   task automatic send_pixels(input req_payload_type px_q[$]);
      int i;
      for (i = 0; i < px_q.size(); i++) begin
         if ($urandom_range(99) < send_idle_pct) begin
            if (i > 0) req_valid <= 1'b0;
            do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
         end
         req_valid <= 1'b1;
         req_data  <= px_q[i];
         do @(negedge clock); while (!req_ready);
         @(posedge clock);
         predict_means(px_q[i]);
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_pixels(input int count);
      req_payload_type px_q[$];
      repeat (count) px_q.push_back(random_pixel());
      send_pixels(px_q);
   endtask

   task automatic wait_idle();
      while (mean_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[CSR_ADDR_W-1:2] == REG_IMAGE_DIM) begin
         dim_cfg = data[DIM_W-1:0];
         row_pos = 0;
         col_pos = 0;
      end
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [CSR_DATA_W-1:0] expected);
      logic [CSR_DATA_W-1:0] got;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== expected) begin
         $display("%0t: register read expected %h actual %h", $time, expected, got);
         error_count++;
      end
   endtask

   // Reset value of the side length, a first row and part of a second at full size.
   task automatic test_reset_state();
      csr_read_check(ADDR_IMAGE_DIM, CSR_DATA_W'(DIM_RESET));
      send_random_pixels(MAX_SIDE + 3);
      wait_idle();
   endtask

   task automatic test_small_extremes();
      req_payload_type px_q[$];
      req_payload_type px;
      int              i;
      // Side 0 behaves as 2: all four pixels are corners.
      csr_write(ADDR_IMAGE_DIM, 32'd0);
      px_q = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'h0000, 16'h0000, 16'h0000},
               '{16'hFFFF, 16'h0000, 16'hAAAA}, '{16'h5555, 16'hFFFF, 16'h0000}};
      send_pixels(px_q);
      wait_idle();
      // Write to the unused index: no restart, side stays 2.
      csr_write(ADDR_SPARE, 32'h0000_0005);
      csr_read_check(ADDR_IMAGE_DIM, 32'd0);
      px_q = '{4{'{16'hFFFF, 16'hFFFF, 16'hFFFF}}};
      send_pixels(px_q);
      wait_idle();
      csr_write(ADDR_IMAGE_DIM, 32'd1);
      px_q = '{'{16'h0001, 16'h8000, 16'h7FFF}, '{16'hFFFE, 16'h0001, 16'h8000},
               '{16'h7FFF, 16'hFFFE, 16'h0001}, '{16'h8000, 16'h7FFF, 16'hFFFE}};
      send_pixels(px_q);
      wait_idle();
      // Upper data bits are dropped: side 3 with corners, edges and one interior.
      csr_write(ADDR_IMAGE_DIM, 32'hFFFF_FC03);
      csr_read_check(ADDR_IMAGE_DIM, 32'd3);
      px_q.delete();
      for (i = 0; i < 9; i++) begin
         px.red   = 16'hFFFF;
         px.green = (i % 2) ? 16'hFFFF : 16'h0000;
         px.blue  = CH_W'(i * 16'h1C71);
         px_q.push_back(px);
      end
      send_pixels(px_q);
      wait_idle();
   endtask

   // Side above the maximum behaves as the maximum: the row end lands on column 511.
   task automatic test_dim_clamp_high();
      csr_write(ADDR_IMAGE_DIM, 32'h0000_03FF);
      csr_read_check(ADDR_IMAGE_DIM, 32'h0000_03FF);
      send_random_pixels(2*MAX_SIDE + 2);
      wait_idle();
   endtask

   task automatic test_random_frames(input int send_pct, input int rsp_pct, input int n_items);
      int   sent, side, eff, total, pick;
      logic complete;
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      sent          = 0;
      complete      = 1'b0;
      side          = 2;
      while (sent < n_items) begin
         // Restart with a fresh side unless the last frame closed and we run on.
         if (!complete || $urandom_range(3) != 0) begin
            pick = $urandom_range(99);
            if (pick < 65)      side = $urandom_range(6, 2);
            else if (pick < 88) side = $urandom_range(12, 7);
            else if (pick < 94) side = $urandom_range(1, 0);
            else                side = $urandom_range(18, 13);
            wait_idle();
            csr_write(ADDR_IMAGE_DIM, ($urandom & ~32'h3FF) | side);
         end
         eff   = (side < 2) ? 2 : side;
         total = eff * eff;
         // Cut some frames short.
         if ($urandom_range(5) == 0) total = $urandom_range(total - 1, 1);
         complete = (total == eff * eff);
         send_random_pixels(total);
         sent += total;
      end
      wait_idle();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_small_extremes();
      test_dim_clamp_high();
      test_random_frames(30, 85, 145);
      test_random_frames(85, 30, 145);
      test_random_frames(0, 0, 145);
      wait_idle();
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
